// File: hw/rtl/easing_tween_generator_assert.svh
// Assertion macros shared by the divider, sequencer and top-level tween generator modules
`ifndef EASING_TWEEN_GENERATOR_ASSERT_SVH
`define EASING_TWEEN_GENERATOR_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define ETG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define ETG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/etg_pkg.sv
package etg_pkg;

  localparam int FRAC_BITS = 16;
  localparam int TIME_BITS = 24;
  localparam int TAB_BITS  = 10;
  localparam int TAB_N     = 1 << TAB_BITS;
  localparam int PC_BITS   = 5;

  localparam logic [63:0] Q30_LN2     = 64'd744261118;
  localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
  localparam logic [16:0] ONE         = 17'h10000;

  // Register indexes of the configuration port
  localparam logic [1:0] REG_CURVE_MODE = 2'd0;
  localparam logic [1:0] REG_START      = 2'd1;
  localparam logic [1:0] REG_CHANGE     = 2'd2;
  localparam logic [1:0] REG_DURATION   = 2'd3;

  // Curve codes
  localparam logic [3:0] MODE_LINEAR   = 4'd0;
  localparam logic [3:0] MODE_QUAD_IN  = 4'd1;
  localparam logic [3:0] MODE_QUAD_OUT = 4'd2;
  localparam logic [3:0] MODE_QUAD_IO  = 4'd3;
  localparam logic [3:0] MODE_SINE_IN  = 4'd4;
  localparam logic [3:0] MODE_SINE_OUT = 4'd5;
  localparam logic [3:0] MODE_SINE_IO  = 4'd6;
  localparam logic [3:0] MODE_ELAS_IN  = 4'd7;
  localparam logic [3:0] MODE_ELAS_OUT = 4'd8;
  localparam logic [3:0] MODE_ELAS_IO  = 4'd9;
  localparam logic [3:0] MODE_EXPO_IN  = 4'd10;
  localparam logic [3:0] MODE_EXPO_OUT = 4'd11;
  localparam logic [3:0] MODE_EXPO_IO  = 4'd12;

  typedef enum logic [3:0] {
    OP_NOP, OP_TIME, OP_DIVGO, OP_LOADU, OP_LIN, OP_QUAD, OP_SINA, OP_WSET,
    OP_ETURN, OP_ROMA, OP_ROMD, OP_SINE, OP_ELAS, OP_EXPO, OP_SCALE, OP_FIN
  } op_e;

  typedef enum logic [2:0] {
    J_NEXT, J_GOTO, J_WAIT, J_EARLY, J_BUSY, J_MODE, J_END
  } jmp_e;

  typedef enum logic [2:0] {
    CLS_LIN, CLS_QUAD, CLS_SINE, CLS_ELAS, CLS_EXPO
  } cls_e;

  typedef struct packed {
    op_e                op;
    jmp_e               jmp;
    logic [PC_BITS-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic [3:0]           mode;
    logic signed [31:0]   start;
    logic signed [31:0]   change;
    logic [TIME_BITS-1:0] dur;
  } cfg_t;

  // Sequencer to datapath
  typedef struct packed {
    op_e  op;
    logic in_acc;
  } ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic early;
    logic busy;
    cls_e cls;
  } stat_t;

  typedef logic [FRAC_BITS:0] sin_tab_t [TAB_N+1];
  typedef logic [FRAC_BITS:0] exp_tab_t [TAB_N];

  function automatic logic [FRAC_BITS:0] q30_to_frac(longint v);
    logic [63:0] r;
    if (v < 0) v = 0;
    r = (64'(v) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    if (r > 64'(ONE)) r = 64'(ONE);
    return r[FRAC_BITS:0];
  endfunction

  // Quarter-wave sine, series in Q30
  function automatic sin_tab_t build_sin();
    sin_tab_t    t;
    logic [63:0] x, x2, term;
    longint      sum;
    for (int k = 0; k <= TAB_N; k++) begin
      x    = (64'(k) * Q30_HALF_PI) >> TAB_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 10; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) sum = sum - longint'(term);
        else            sum = sum + longint'(term);
      end
      t[k] = q30_to_frac(sum);
    end
    return t;
  endfunction

  // 2^-x over one octave, series in Q30
  function automatic exp_tab_t build_exp();
    exp_tab_t    t;
    logic [63:0] y, term;
    longint      sum;
    for (int k = 0; k < TAB_N; k++) begin
      y    = (64'(k) * Q30_LN2) >> TAB_BITS;
      term = 64'd1 << 30;
      sum  = longint'(term);
      for (int n = 1; n <= 16; n++) begin
        term = ((term * y) >> 30) / 64'(n);
        if (n % 2 == 1) sum = sum - longint'(term);
        else            sum = sum + longint'(term);
      end
      t[k] = q30_to_frac(sum);
    end
    return t;
  endfunction

endpackage

// File: hw/rtl/etg_div.sv
`include "easing_tween_generator_assert.svh"

// Restoring divider for the phase: quotient of (num << FRAC_BITS) / den, num < den
module etg_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [etg_pkg::TIME_BITS-1:0]     num_i,
  input  logic [etg_pkg::TIME_BITS-1:0]     den_i,
  output logic                              busy_o,
  output logic [etg_pkg::FRAC_BITS-1:0]     quot_o
);

  localparam int CNT_BITS = $clog2(etg_pkg::FRAC_BITS + 1);

  logic                          busy_q;
  logic [CNT_BITS-1:0]           cnt_q;
  logic [etg_pkg::TIME_BITS-1:0] rem_q;
  logic [etg_pkg::FRAC_BITS-1:0] quot_q;
  logic [etg_pkg::TIME_BITS:0]   r2_c;
  logic [etg_pkg::TIME_BITS:0]   diff_c;
  logic                          ge_c;

  // Shift in one zero, try the subtract
  assign r2_c   = {rem_q, 1'b0};
  assign diff_c = r2_c - {1'b0, den_i};
  assign ge_c   = r2_c >= {1'b0, den_i};

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_BITS'(etg_pkg::FRAC_BITS);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_BITS'(1)) busy_q <= 1'b0;
    end
  end

  // Remainder and quotient, one bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge_c ? diff_c[etg_pkg::TIME_BITS-1:0] : r2_c[etg_pkg::TIME_BITS-1:0];
      quot_q <= {quot_q[etg_pkg::FRAC_BITS-2:0], ge_c};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

  `ETG_ASSERT_NXT(a_div_start_busy, start_i, busy_q && cnt_q == CNT_BITS'(etg_pkg::FRAC_BITS),
                  "divider did not start")

endmodule

// File: hw/rtl/etg_seq.sv
`include "easing_tween_generator_assert.svh"

// Microcode sequencer: step counter over a fixed control store
module etg_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            out_free_i,
  input  etg_pkg::stat_t  stat_i,
  output etg_pkg::ctrl_t  ctrl_o,
  output logic            in_ready_o,
  output logic            out_load_o
);

  localparam logic [etg_pkg::PC_BITS-1:0] PC_IDLE  = 5'd0;
  localparam logic [etg_pkg::PC_BITS-1:0] PC_DIVWT = 5'd3;
  localparam logic [etg_pkg::PC_BITS-1:0] PC_LIN   = 5'd5;
  localparam logic [etg_pkg::PC_BITS-1:0] PC_QUAD  = 5'd6;
  localparam logic [etg_pkg::PC_BITS-1:0] PC_SINE  = 5'd7;
  localparam logic [etg_pkg::PC_BITS-1:0] PC_ELAS  = 5'd11;
  localparam logic [etg_pkg::PC_BITS-1:0] PC_EXPO  = 5'd16;
  localparam logic [etg_pkg::PC_BITS-1:0] PC_SCALE = 5'd20;
  localparam logic [etg_pkg::PC_BITS-1:0] PC_END   = 5'd22;

  function automatic etg_pkg::ucode_t uword(logic [etg_pkg::PC_BITS-1:0] pc);
    etg_pkg::ucode_t w;
    w = '{op: etg_pkg::OP_NOP, jmp: etg_pkg::J_GOTO, target: PC_IDLE};
    unique case (pc)
      5'd0:  w = '{etg_pkg::OP_NOP,   etg_pkg::J_WAIT,  PC_IDLE};
      5'd1:  w = '{etg_pkg::OP_TIME,  etg_pkg::J_EARLY, PC_END};
      5'd2:  w = '{etg_pkg::OP_DIVGO, etg_pkg::J_NEXT,  PC_IDLE};
      5'd3:  w = '{etg_pkg::OP_NOP,   etg_pkg::J_BUSY,  PC_IDLE};
      5'd4:  w = '{etg_pkg::OP_LOADU, etg_pkg::J_MODE,  PC_IDLE};
      5'd5:  w = '{etg_pkg::OP_LIN,   etg_pkg::J_GOTO,  PC_SCALE};
      5'd6:  w = '{etg_pkg::OP_QUAD,  etg_pkg::J_GOTO,  PC_SCALE};
      5'd7:  w = '{etg_pkg::OP_SINA,  etg_pkg::J_NEXT,  PC_IDLE};
      5'd8:  w = '{etg_pkg::OP_ROMA,  etg_pkg::J_NEXT,  PC_IDLE};
      5'd9:  w = '{etg_pkg::OP_ROMD,  etg_pkg::J_NEXT,  PC_IDLE};
      5'd10: w = '{etg_pkg::OP_SINE,  etg_pkg::J_GOTO,  PC_SCALE};
      5'd11: w = '{etg_pkg::OP_WSET,  etg_pkg::J_NEXT,  PC_IDLE};
      5'd12: w = '{etg_pkg::OP_ETURN, etg_pkg::J_NEXT,  PC_IDLE};
      5'd13: w = '{etg_pkg::OP_ROMA,  etg_pkg::J_NEXT,  PC_IDLE};
      5'd14: w = '{etg_pkg::OP_ROMD,  etg_pkg::J_NEXT,  PC_IDLE};
      5'd15: w = '{etg_pkg::OP_ELAS,  etg_pkg::J_GOTO,  PC_SCALE};
      5'd16: w = '{etg_pkg::OP_WSET,  etg_pkg::J_NEXT,  PC_IDLE};
      5'd17: w = '{etg_pkg::OP_ROMA,  etg_pkg::J_NEXT,  PC_IDLE};
      5'd18: w = '{etg_pkg::OP_ROMD,  etg_pkg::J_NEXT,  PC_IDLE};
      5'd19: w = '{etg_pkg::OP_EXPO,  etg_pkg::J_NEXT,  PC_IDLE};
      5'd20: w = '{etg_pkg::OP_SCALE, etg_pkg::J_NEXT,  PC_IDLE};
      5'd21: w = '{etg_pkg::OP_FIN,   etg_pkg::J_NEXT,  PC_IDLE};
      5'd22: w = '{etg_pkg::OP_NOP,   etg_pkg::J_END,   PC_IDLE};
      default: w = '{etg_pkg::OP_NOP, etg_pkg::J_GOTO,  PC_IDLE};
    endcase
    return w;
  endfunction

  logic [etg_pkg::PC_BITS-1:0] pc_q, pc_d;
  etg_pkg::ucode_t             uw_c;
  logic                        in_acc_c;
  logic                        load_c;

  assign uw_c     = uword(pc_q);
  assign in_acc_c = (uw_c.jmp == etg_pkg::J_WAIT) && in_valid_i;

  // Next step
  always_comb begin
    pc_d   = pc_q + 1'b1;
    load_c = 1'b0;
    unique case (uw_c.jmp)
      etg_pkg::J_NEXT:  pc_d = pc_q + 1'b1;
      etg_pkg::J_GOTO:  pc_d = uw_c.target;
      etg_pkg::J_WAIT:  pc_d = in_valid_i ? pc_q + 1'b1 : pc_q;
      etg_pkg::J_EARLY: pc_d = stat_i.early ? uw_c.target : pc_q + 1'b1;
      etg_pkg::J_BUSY:  pc_d = stat_i.busy ? pc_q : pc_q + 1'b1;
      etg_pkg::J_MODE: begin
        unique case (stat_i.cls)
          etg_pkg::CLS_QUAD: pc_d = PC_QUAD;
          etg_pkg::CLS_SINE: pc_d = PC_SINE;
          etg_pkg::CLS_ELAS: pc_d = PC_ELAS;
          etg_pkg::CLS_EXPO: pc_d = PC_EXPO;
          default:           pc_d = PC_LIN;
        endcase
      end
      etg_pkg::J_END: begin
        load_c = out_free_i;
        pc_d   = out_free_i ? PC_IDLE : pc_q;
      end
      default: pc_d = PC_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pc_q <= PC_IDLE;
    else         pc_q <= pc_d;
  end

  assign ctrl_o.op     = uw_c.op;
  assign ctrl_o.in_acc = in_acc_c;
  assign in_ready_o    = uw_c.jmp == etg_pkg::J_WAIT;
  assign out_load_o    = load_c;

  `ETG_ASSERT_NOW(a_seq_busy_wait, stat_i.busy, pc_q == PC_DIVWT,
                  "divider running outside the wait step")
  `ETG_ASSERT_NXT(a_seq_load_idle, load_c, pc_q == PC_IDLE,
                  "sequencer did not return to idle after a result")

endmodule

// File: hw/rtl/etg_dp.sv
// Datapath: time counter, phase, curve evaluation and scaling
module etg_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  etg_pkg::cfg_t         cfg_i,
  input  etg_pkg::ctrl_t        ctrl_i,
  input  logic                  opcode_i,
  input  logic [15:0]           delta_i,
  output etg_pkg::stat_t        stat_o,
  output logic [31:0]           res_o,
  output logic                  done_o
);

  localparam int TB = etg_pkg::TIME_BITS;
  localparam int FB = etg_pkg::FRAC_BITS;
  localparam logic [etg_pkg::TAB_BITS:0] TAB_TOP = (etg_pkg::TAB_BITS+1)'(etg_pkg::TAB_N);
  localparam etg_pkg::sin_tab_t SIN_TAB = etg_pkg::build_sin();
  localparam etg_pkg::exp_tab_t EXP_TAB = etg_pkg::build_exp();
  localparam logic signed [18:0] ONE19 = 19'sd65536;
  localparam logic [63:0] RECIP3 = 64'hAAAAAAAB;
  localparam logic [63:0] RECIP9 = 64'h38E38E39;

  logic                 op_q;
  logic [15:0]          delta_q;
  logic [TB-1:0]        el_q;
  logic                 fin_q;
  logic [FB-1:0]        u_q;
  logic signed [17:0]   w_q;
  logic [FB:0]          v_q;
  logic [FB-1:0]        tf_q;
  logic [FB:0]          sin_rd_q, exp_rd_q;
  logic                 neg_q;
  logic [3:0]           shf_q;
  logic signed [17:0]   s_q;
  logic [FB:0]          p_q;
  logic signed [18:0]   e_q;
  logic signed [50:0]   prod_q;
  logic [31:0]          res_q;
  logic                 done_q;

  logic [TB:0]          sum_c;
  logic [TB-1:0]        sat_c;
  logic                 reach_c;
  logic                 div_busy;
  logic [FB-1:0]        quot;
  etg_pkg::cls_e        cls_c;
  logic [31:0]          fullval_c;

  // Saturating time update
  assign sum_c   = {1'b0, el_q} + (TB+1)'(delta_q);
  assign sat_c   = sum_c[TB] ? {TB{1'b1}} : sum_c[TB-1:0];
  assign reach_c = sat_c >= cfg_i.dur;
  assign fullval_c = cfg_i.start + cfg_i.change;

  // Curve family of the mode
  always_comb begin
    case (cfg_i.mode)
      etg_pkg::MODE_QUAD_IN, etg_pkg::MODE_QUAD_OUT, etg_pkg::MODE_QUAD_IO:
        cls_c = etg_pkg::CLS_QUAD;
      etg_pkg::MODE_SINE_IN, etg_pkg::MODE_SINE_OUT, etg_pkg::MODE_SINE_IO:
        cls_c = etg_pkg::CLS_SINE;
      etg_pkg::MODE_ELAS_IN, etg_pkg::MODE_ELAS_OUT, etg_pkg::MODE_ELAS_IO:
        cls_c = etg_pkg::CLS_ELAS;
      etg_pkg::MODE_EXPO_IN, etg_pkg::MODE_EXPO_OUT, etg_pkg::MODE_EXPO_IO:
        cls_c = etg_pkg::CLS_EXPO;
      default: cls_c = etg_pkg::CLS_LIN;
    endcase
  end

  etg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(ctrl_i.op == etg_pkg::OP_DIVGO),
    .num_i  (el_q),
    .den_i  (cfg_i.dur),
    .busy_o (div_busy),
    .quot_o (quot)
  );

  // Operand forms of the phase
  logic [FB:0]          u17_c, omu_c;
  logic signed [17:0]   w2_c;
  logic [FB:0]          w2abs_c;
  assign u17_c   = {1'b0, u_q};
  assign omu_c   = ONE_17() - u17_c;
  assign w2_c    = $signed({1'b0, u_q, 1'b0}) - 18'sd65536;
  assign w2abs_c = w2_c[17] ? 17'(-w2_c) : w2_c[16:0];

  function automatic logic [FB:0] ONE_17();
    return etg_pkg::ONE;
  endfunction

  // Quadratic curves
  logic [31:0] uu_c;
  logic [33:0] uo_c;
  logic [33:0] dd_c;
  logic signed [18:0] quad_c;
  assign uu_c = u_q * u_q;
  assign uo_c = 34'(u17_c) * (34'(etg_pkg::ONE) * 34'd2 - 34'(u17_c));
  assign dd_c = 34'(omu_c) * 34'(omu_c);
  always_comb begin
    case (cfg_i.mode)
      etg_pkg::MODE_QUAD_IN:  quad_c = 19'(uu_c >> 16);
      etg_pkg::MODE_QUAD_OUT: quad_c = 19'(uo_c >> 16);
      default: quad_c = !u_q[FB-1] ? 19'(uu_c >> 15) : ONE19 - 19'(dd_c >> 15);
    endcase
  end

  // Elastic turn count: (w*10 + 3*2^20)/3 or (w*20 + 9*2^21)/9, less a quarter
  logic signed [26:0] x_c;
  logic [63:0]        em_c;
  logic [FB-1:0]      tfe_c;
  assign x_c   = (cfg_i.mode == etg_pkg::MODE_ELAS_IO)
               ? 27'(w_q) * 27'sd20 + 27'sd18874368
               : 27'(w_q) * 27'sd10 + 27'sd3145728;
  assign em_c  = 64'(x_c[25:0]) *
                 ((cfg_i.mode == etg_pkg::MODE_ELAS_IO) ? RECIP9 : RECIP3);
  assign tfe_c = em_c[33+FB-1:33] - 16'd16384;

  // Table addresses
  logic [etg_pkg::TAB_BITS+1:0] sidx_c;
  logic [etg_pkg::TAB_BITS:0]   saddr_c;
  logic [19:0]                  t_c;
  assign sidx_c  = tf_q[FB-1 -: etg_pkg::TAB_BITS+2];
  assign saddr_c = sidx_c[0+etg_pkg::TAB_BITS]
                 ? TAB_TOP - {1'b0, sidx_c[etg_pkg::TAB_BITS-1:0]}
                 : {1'b0, sidx_c[etg_pkg::TAB_BITS-1:0]};
  assign t_c     = 20'(v_q) * 20'd10;

  // Elastic product
  logic signed [35:0] pm_c;
  logic signed [35:0] sh16_c, sh17_c;
  assign pm_c   = $signed({19'b0, p_q}) * 36'(s_q);
  assign sh16_c = pm_c >>> 16;
  assign sh17_c = pm_c >>> 17;

  logic signed [47:0] rnd_c;
  assign rnd_c = prod_q[47:0] + 48'sd32768;

  // Item and time state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      el_q  <= '0;
      fin_q <= 1'b0;
    end else if (ctrl_i.op == etg_pkg::OP_TIME) begin
      if (op_q) begin
        el_q  <= '0;
        fin_q <= 1'b0;
      end else if (!fin_q) begin
        el_q <= sat_c;
        if (reach_c) fin_q <= 1'b1;
      end
    end
  end

  // Working registers, driven by the control word
  always_ff @(posedge clk_i) begin
    if (ctrl_i.in_acc) begin
      op_q    <= opcode_i;
      delta_q <= delta_i;
    end
    case (ctrl_i.op)
      etg_pkg::OP_TIME: begin
        if (op_q) begin
          res_q  <= cfg_i.start;
          done_q <= 1'b0;
        end else if (fin_q || reach_c) begin
          res_q  <= fullval_c;
          done_q <= 1'b1;
        end else begin
          done_q <= 1'b0;
        end
      end
      etg_pkg::OP_LOADU: u_q <= quot;
      etg_pkg::OP_LIN:   e_q <= 19'(u17_c);
      etg_pkg::OP_QUAD:  e_q <= quad_c;
      etg_pkg::OP_SINA: begin
        case (cfg_i.mode)
          etg_pkg::MODE_SINE_OUT: tf_q <= u_q >> 2;
          etg_pkg::MODE_SINE_IO:  tf_q <= (u_q >> 1) + 16'd16384;
          default:                tf_q <= (u_q >> 2) + 16'd16384;
        endcase
        v_q <= '0;
      end
      etg_pkg::OP_WSET: begin
        case (cfg_i.mode)
          etg_pkg::MODE_ELAS_IN: begin
            w_q <= $signed({2'b0, u_q}) - 18'sd65536;
            v_q <= omu_c;
          end
          etg_pkg::MODE_ELAS_OUT: begin
            w_q <= $signed({2'b0, u_q});
            v_q <= u17_c;
          end
          etg_pkg::MODE_ELAS_IO: begin
            w_q <= w2_c;
            v_q <= w2abs_c;
          end
          etg_pkg::MODE_EXPO_IN:  v_q <= omu_c;
          etg_pkg::MODE_EXPO_OUT: v_q <= u17_c;
          default:                v_q <= w2abs_c;
        endcase
      end
      etg_pkg::OP_ETURN: tf_q <= tfe_c;
      etg_pkg::OP_ROMA: begin
        sin_rd_q <= SIN_TAB[saddr_c];
        neg_q    <= sidx_c[etg_pkg::TAB_BITS+1];
        exp_rd_q <= EXP_TAB[t_c[FB-1 -: etg_pkg::TAB_BITS]];
        shf_q    <= t_c[19:16];
      end
      etg_pkg::OP_ROMD: begin
        s_q <= neg_q ? -$signed({1'b0, sin_rd_q}) : $signed({1'b0, sin_rd_q});
        p_q <= exp_rd_q >> shf_q;
      end
      etg_pkg::OP_SINE: begin
        case (cfg_i.mode)
          etg_pkg::MODE_SINE_OUT: e_q <= 19'(s_q);
          etg_pkg::MODE_SINE_IO:  e_q <= (ONE19 - 19'(s_q)) >>> 1;
          default:                e_q <= ONE19 - 19'(s_q);
        endcase
      end
      etg_pkg::OP_ELAS: begin
        if (u_q == '0)                             e_q <= '0;
        else if (cfg_i.mode == etg_pkg::MODE_ELAS_IN)  e_q <= -19'(sh16_c);
        else if (cfg_i.mode == etg_pkg::MODE_ELAS_OUT) e_q <= ONE19 + 19'(sh16_c);
        else if (w_q[17])                          e_q <= -19'(sh17_c);
        else                                       e_q <= ONE19 + 19'(sh17_c);
      end
      etg_pkg::OP_EXPO: begin
        case (cfg_i.mode)
          etg_pkg::MODE_EXPO_IN:  e_q <= (u_q == '0) ? 19'sd0 : 19'(p_q);
          etg_pkg::MODE_EXPO_OUT: e_q <= ONE19 - 19'(p_q);
          default: begin
            if (u_q == '0)        e_q <= '0;
            else if (!u_q[FB-1])  e_q <= 19'(p_q >> 1);
            else                  e_q <= ONE19 - 19'(p_q >> 1);
          end
        endcase
      end
      etg_pkg::OP_SCALE: prod_q <= 51'(cfg_i.change) * 51'(e_q);
      etg_pkg::OP_FIN: begin
        res_q <= cfg_i.start + rnd_c[47:16];
      end
      default: ;
    endcase
  end

  assign stat_o.early = op_q || fin_q || reach_c;
  assign stat_o.busy  = div_busy;
  assign stat_o.cls   = cls_c;
  assign res_o  = res_q;
  assign done_o = done_q;

endmodule

// File: hw/rtl/easing_tween_generator.sv
// A restart or a finished tween goes from the accepted item straight to its result, while
// any other item passes through the bit-serial phase divider, the curve steps and scaling.
// Throughput: one item at a time; the next item is taken once the result is loaded into the
// output register.
// Reset: asynchronous, active low; clears the time counter, the finished flag, the
// sequencer and the output valid, and loads the configuration reset values.
`include "easing_tween_generator_assert.svh"

module easing_tween_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] delta_ticks
  input  logic        s_axis_tuser,   // [0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] eased_value
  output logic        m_axis_tuser,   // [0] done_res
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  etg_pkg::cfg_t  cfg_q;
  etg_pkg::ctrl_t ctrl;
  etg_pkg::stat_t stat;
  logic           out_load;
  logic           out_valid_q;
  logic [31:0]    out_data_q;
  logic           out_user_q;
  logic [31:0]    res;
  logic           done;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode   <= etg_pkg::MODE_LINEAR;
      cfg_q.start  <= 32'sd0;
      cfg_q.change <= 32'sd65536;
      cfg_q.dur    <= 24'd2000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        etg_pkg::REG_CURVE_MODE: cfg_q.mode   <= cfg_wdata_i[3:0];
        etg_pkg::REG_START:      cfg_q.start  <= cfg_wdata_i;
        etg_pkg::REG_CHANGE:     cfg_q.change <= cfg_wdata_i;
        etg_pkg::REG_DURATION:   cfg_q.dur    <= cfg_wdata_i[etg_pkg::TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

  etg_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .out_free_i(!out_valid_q || m_axis_tready),
    .stat_i    (stat),
    .ctrl_o    (ctrl),
    .in_ready_o(s_axis_tready),
    .out_load_o(out_load)
  );

  etg_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .ctrl_i  (ctrl),
    .opcode_i(s_axis_tuser),
    .delta_i (s_axis_tdata),
    .stat_o  (stat),
    .res_o   (res),
    .done_o  (done)
  );

  // Output register: hold a result until its transaction completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)       out_valid_q <= 1'b0;
    else if (out_load) out_valid_q <= 1'b1;
    else if (m_axis_tready) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= res;
      out_user_q <= done;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  `ETG_ASSERT_NXT(a_top_accept_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready,
                  "second item accepted while one is in work")
  `ETG_ASSERT_NXT(a_top_load_valid, out_load, m_axis_tvalid,
                  "loaded result not presented")

endmodule
